### design/i2crts_pkg.sv
// Package for the I2C register transaction sequencer.
// Holds action codes, phase counts, address and slot constants, and the position and pin structs.
// No dependencies.
`default_nettype none

package i2crts_pkg;

    // Action codes of an input transaction
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam int PHASE_W = 7;

    // Phase counts of the two bus transactions
    localparam logic [PHASE_W-1:0] WRITE_PHASES = 7'd87;
    localparam logic [PHASE_W-1:0] READ_PHASES  = 7'd57;
    localparam logic [PHASE_W-1:0] START_PHASES = 7'd3;
    localparam logic [PHASE_W-1:0] STOP_PHASES  = 7'd3;

    // Fixed high bits of the 7-bit device address
    localparam logic [3:0] ADDR_PREFIX = 4'b0100;

    // Slot layout: eight data bits and one ACK bit, three phases each
    localparam logic [3:0] ACK_BIT  = 4'd8;
    localparam logic [1:0] SUB_LAST = 2'd2;
    localparam logic [1:0] SUB_HIGH = 2'd1;

    // Position of the next phase inside the transaction
    typedef struct packed {
        logic [PHASE_W-1:0] phase;    // phase index from the start
        logic [1:0]         sub;      // phase within a bit: low, high, low
        logic [3:0]         bit_idx;  // bit within a slot, ACK_BIT for the ACK
        logic [1:0]         seg;      // slot: address, register, value
    } t_pos;

    // Pin levels and flags that one phase produces
    typedef struct packed {
        logic scl;
        logic sda;
        logic last;
        logic sample;
    } t_pins;

endpackage

`default_nettype wire

### design/i2crts_pins.sv
// Pin decode for one phase of an I2C transaction.
// Depends on i2crts_pkg for the position struct and phase counts.
`default_nettype none

module i2crts_pins (
    input  var i2crts_pkg::t_pos  i_pos,
    input  wire                   i_is_read,
    input  wire  [7:0]            i_addr_byte,
    input  wire  [7:0]            i_reg_byte,
    input  wire  [7:0]            i_val_byte,
    output i2crts_pkg::t_pins     o_pins
);

    logic [i2crts_pkg::PHASE_W-1:0] total;
    logic [i2crts_pkg::PHASE_W-1:0] stop_base;
    logic [i2crts_pkg::PHASE_W-1:0] stop_off;
    logic [7:0]                     sel_byte;
    logic                           in_start;
    logic                           in_stop;

    // Locate the phase in start, data or stop region
    assign total     = i_is_read ? i2crts_pkg::READ_PHASES : i2crts_pkg::WRITE_PHASES;
    assign stop_base = total - i2crts_pkg::STOP_PHASES;
    assign stop_off  = i_pos.phase - stop_base;
    assign in_start  = i_pos.phase < i2crts_pkg::START_PHASES;
    assign in_stop   = i_pos.phase >= stop_base;

    // Pick the byte of the current slot
    always_comb begin
        case (i_pos.seg)
            2'd0:    sel_byte = i_addr_byte;
            2'd1:    sel_byte = i_reg_byte;
            default: sel_byte = i_val_byte;
        endcase
    end

    // Drive pins for the phase
    always_comb begin
        o_pins.last   = 1'b0;
        o_pins.sample = 1'b0;
        if (in_start) begin
            o_pins.scl = i_pos.phase < 7'd2;
            o_pins.sda = i_pos.phase == 7'd0;
        end else if (in_stop) begin
            o_pins.scl  = stop_off >= 7'd1;
            o_pins.sda  = stop_off == 7'd2;
            o_pins.last = stop_off == 7'd2;
        end else begin
            o_pins.scl = i_pos.sub == i2crts_pkg::SUB_HIGH;
            if (i_pos.bit_idx == i2crts_pkg::ACK_BIT || (i_is_read && i_pos.seg != 2'd0)) begin
                o_pins.sda = 1'b1;
            end else begin
                o_pins.sda = sel_byte[~i_pos.bit_idx[2:0]];
            end
            // Take SDA after each data bit's high phase in the read slot
            o_pins.sample = i_is_read && i_pos.seg == 2'd1 &&
                            i_pos.sub == i2crts_pkg::SUB_LAST &&
                            i_pos.bit_idx != i2crts_pkg::ACK_BIT;
        end
    end

endmodule

`default_nettype wire

### design/i2c_register_transaction_sequencer.sv
// Top level of the I2C register transaction sequencer.
// Depends on i2crts_pkg and i2crts_pins.
//
//   channel | direction | handshake                     | payload
//   in      | input     | i_in_valid / o_in_ready       | action, select, register, value, sda
//   out     | output    | o_out_valid / i_out_ready     | scl, sda, busy, last, read data, rejected
//
// One transaction in and one out per clock when the output is taken; a transaction passes
// an input register, then the phase decode into the result register.
// The phase position counters are updated as a transaction leaves the input register.
// Reset (synchronous, active low) empties both registers and returns the bus to idle.
// A stalled output holds its result; the input register still takes one more item.
`default_nettype none

module i2c_register_transaction_sequencer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_action,
    input  wire  [2:0]  i_device_select,
    input  wire  [7:0]  i_register_index,
    input  wire  [7:0]  i_write_value,
    input  wire         i_sda_sample,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_scl,
    output logic        o_sda_release,
    output logic        o_busy_res,
    output logic        o_last_phase,
    output logic [7:0]  o_read_data,
    output logic        o_rejected
);

    // Input register
    logic       r_in_valid;
    logic [1:0] r_action;
    logic [2:0] r_select;
    logic [7:0] r_reg_idx;
    logic [7:0] r_wr_val;
    logic       r_sample;

    // Transaction state
    logic                  r_active;
    logic                  r_is_read;
    logic [2:0]            r_dev_sel;
    logic [7:0]            r_reg_byte;
    logic [7:0]            r_val_byte;
    logic [7:0]            r_shift;
    i2crts_pkg::t_pos      r_pos;

    logic                  n_active;
    logic                  n_is_read;
    logic [2:0]            n_dev_sel;
    logic [7:0]            n_reg_byte;
    logic [7:0]            n_val_byte;
    logic [7:0]            n_shift;
    i2crts_pkg::t_pos      n_pos;

    // Result register
    logic       r_out_valid;
    logic       r_scl;
    logic       r_sda;
    logic       r_busy;
    logic       r_last;
    logic [7:0] r_rdata;
    logic       r_rej;

    logic       n_scl;
    logic       n_sda;
    logic       n_busy;
    logic       n_last;
    logic [7:0] n_rdata;
    logic       n_rej;

    logic                  move;
    logic                  is_cmd;
    logic                  start;
    logic                  cur_read;
    logic [2:0]            cur_sel;
    logic [7:0]            cur_reg;
    logic [7:0]            cur_val;
    logic [7:0]            cur_shift;
    logic [7:0]            shifted;
    logic [7:0]            cur_addr;
    i2crts_pkg::t_pos      cur_pos;
    i2crts_pkg::t_pos      adv_pos;
    i2crts_pkg::t_pins     pins;

    // Handshake: advance when the result register is free or being drained
    assign move       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || move;

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_action  <= i_action;
            r_select  <= i_device_select;
            r_reg_idx <= i_register_index;
            r_wr_val  <= i_write_value;
            r_sample  <= i_sda_sample;
        end
    end

    // Select the state in effect: a command on an idle bus starts fresh
    assign is_cmd    = r_action == i2crts_pkg::ACT_WRITE || r_action == i2crts_pkg::ACT_READ;
    assign start     = !r_active && is_cmd;
    assign cur_read  = start ? (r_action == i2crts_pkg::ACT_READ) : r_is_read;
    assign cur_sel   = start ? r_select  : r_dev_sel;
    assign cur_reg   = start ? r_reg_idx : r_reg_byte;
    assign cur_val   = start ? r_wr_val  : r_val_byte;
    assign cur_shift = start ? 8'd0      : r_shift;
    assign cur_pos   = start ? '0        : r_pos;
    assign cur_addr  = {i2crts_pkg::ADDR_PREFIX, cur_sel, cur_read};

    i2crts_pins u_pins (
        .i_pos       (cur_pos),
        .i_is_read   (cur_read),
        .i_addr_byte (cur_addr),
        .i_reg_byte  (cur_reg),
        .i_val_byte  (cur_val),
        .o_pins      (pins)
    );

    assign shifted = pins.sample ? {cur_shift[6:0], r_sample} : cur_shift;

    // Step the position: phase always, bit counters only after the start region
    always_comb begin
        adv_pos       = cur_pos;
        adv_pos.phase = cur_pos.phase + 7'd1;
        if (cur_pos.phase >= i2crts_pkg::START_PHASES) begin
            if (cur_pos.sub == i2crts_pkg::SUB_LAST) begin
                adv_pos.sub = 2'd0;
                if (cur_pos.bit_idx == i2crts_pkg::ACK_BIT) begin
                    adv_pos.bit_idx = 4'd0;
                    adv_pos.seg     = cur_pos.seg + 2'd1;
                end else begin
                    adv_pos.bit_idx = cur_pos.bit_idx + 4'd1;
                end
            end else begin
                adv_pos.sub = cur_pos.sub + 2'd1;
            end
        end
    end

    // Form next state and the result
    always_comb begin
        n_active   = r_active;
        n_is_read  = cur_read;
        n_dev_sel  = cur_sel;
        n_reg_byte = cur_reg;
        n_val_byte = cur_val;
        n_shift    = cur_shift;
        n_pos      = cur_pos;
        n_scl      = 1'b1;
        n_sda      = 1'b1;
        n_busy     = 1'b0;
        n_last     = 1'b0;
        n_rdata    = 8'd0;
        n_rej      = r_active && is_cmd;
        if (r_active || start) begin
            n_busy  = 1'b1;
            n_scl   = pins.scl;
            n_sda   = pins.sda;
            n_shift = shifted;
            if (pins.last) begin
                n_last   = 1'b1;
                n_rdata  = cur_read ? shifted : 8'd0;
                n_active = 1'b0;
                n_pos    = '0;
            end else begin
                n_active = 1'b1;
                n_pos    = adv_pos;
            end
        end
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_is_read   <= 1'b0;
            r_dev_sel   <= 3'd0;
            r_reg_byte  <= 8'd0;
            r_val_byte  <= 8'd0;
            r_shift     <= 8'd0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (move) begin
                r_active    <= n_active;
                r_is_read   <= n_is_read;
                r_dev_sel   <= n_dev_sel;
                r_reg_byte  <= n_reg_byte;
                r_val_byte  <= n_val_byte;
                r_shift     <= n_shift;
                r_pos       <= n_pos;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (move) begin
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_busy  <= n_busy;
            r_last  <= n_last;
            r_rdata <= n_rdata;
            r_rej   <= n_rej;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl         = r_scl;
    assign o_sda_release = r_sda;
    assign o_busy_res    = r_busy;
    assign o_last_phase  = r_last;
    assign o_read_data   = r_rdata;
    assign o_rejected    = r_rej;

`ifndef NO_ASSERTIONS
    // An idle sequencer keeps its phase position cleared
    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_pos == '0)
        else $error("phase position not cleared while idle");

    // A read never runs past its last phase
    a_read_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_is_read) |-> r_pos.phase < i2crts_pkg::READ_PHASES)
        else $error("read transaction ran past its length");

    // A rejected command only happens during a transaction in progress
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rej) |-> r_busy)
        else $error("command rejected on an idle bus");

    // The final phase ends the transaction
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && n_last) |=> !r_active)
        else $error("transaction still active after its last phase");
`endif

endmodule

`default_nettype wire

### tb/i2c_register_transaction_sequencer_tb.sv
// Testbench for the I2C register transaction sequencer: drives commands and ticks,
// predicts every pin phase and checks each result in order.
// Depends on i2crts_pkg and the i2c_register_transaction_sequencer RTL.
`default_nettype none

module i2c_register_transaction_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 800;
    localparam int MAX_GAP        = 30;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;

    // Bit layout of a transaction after the start condition
    localparam int SLOT_LEN          = 27;
    localparam int DATA_LEN          = 24;
    localparam int FIRST_SAMPLE_PHASE = 32;
    localparam int LAST_SAMPLE_PHASE  = 53;

    // How the SDA level seen by the master is chosen per item
    localparam logic [1:0] SDA_RANDOM = 2'd0;
    localparam logic [1:0] SDA_HIGH   = 2'd1;
    localparam logic [1:0] SDA_LOW    = 2'd2;
    localparam logic [1:0] SDA_TOGGLE = 2'd3;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       last;
        logic [7:0] rdata;
        logic       rej;
    } t_phase_result;

    // Predicts the pin phase of every accepted transaction and checks the results
    class i2c_phase_scoreboard;
        logic [6:0]    phase_count;
        bit            in_transfer;
        bit            is_read;
        logic [7:0]    addr_byte;
        logic [7:0]    reg_byte;
        logic [7:0]    val_byte;
        logic [7:0]    rx_shift;
        t_phase_result expected_q[$];
        int            mismatches;
        int            checked;
        int            writes_started;
        int            reads_started;
        int            rejects;

        function new();
            phase_count = '0;
            in_transfer = 0;
            is_read     = 0;
            addr_byte   = '0;
            reg_byte    = '0;
            val_byte    = '0;
            rx_shift    = '0;
        endfunction

        // Pin levels of phase p of the transfer in progress
        function void bus_levels(int p, int total, output logic scl, output logic sda);
            int         q;
            int         seg;
            int         w;
            logic [7:0] byte_out;
            if (p < i2crts_pkg::START_PHASES) begin
                scl = (p < 2);
                sda = (p == 0);
            end else if (p >= total - i2crts_pkg::STOP_PHASES) begin
                scl = (p - (total - i2crts_pkg::STOP_PHASES)) >= 1;
                sda = (p - (total - i2crts_pkg::STOP_PHASES)) == 2;
            end else begin
                q   = p - i2crts_pkg::START_PHASES;
                seg = q / SLOT_LEN;
                w   = q % SLOT_LEN;
                scl = (w % 3) == i2crts_pkg::SUB_HIGH;
                if (w >= DATA_LEN || (is_read && seg >= 1)) begin
                    sda = 1'b1;
                end else begin
                    byte_out = (seg == 0) ? addr_byte : (seg == 1) ? reg_byte : val_byte;
                    sda = byte_out[7 - w / 3];
                end
            end
        endfunction

        // Advance the predicted sequencer by one accepted transaction
        function void note_input(i2crts_pkg::t_action act, logic [2:0] sel,
                                 logic [7:0] reg_idx, logic [7:0] val, logic sda_in);
            t_phase_result r;
            bit            is_cmd;
            int            total;
            int            p;
            r       = '0;
            r.scl   = 1'b1;
            r.sda   = 1'b1;
            is_cmd  = (act == i2crts_pkg::ACT_WRITE) || (act == i2crts_pkg::ACT_READ);
            if (in_transfer) begin
                if (is_cmd) begin
                    r.rej = 1'b1;
                    rejects++;
                end
            end else if (is_cmd) begin
                in_transfer = 1;
                is_read     = (act == i2crts_pkg::ACT_READ);
                addr_byte   = {i2crts_pkg::ADDR_PREFIX, sel, is_read};
                reg_byte    = reg_idx;
                val_byte    = val;
                rx_shift    = '0;
                phase_count = '0;
                if (is_read) reads_started++;
                else writes_started++;
            end
            if (in_transfer) begin
                total  = is_read ? i2crts_pkg::READ_PHASES : i2crts_pkg::WRITE_PHASES;
                p      = phase_count;
                if (p >= total) p = total - 1;
                r.busy = 1'b1;
                // shift in the level seen during the previous SCL-high data phase
                if (is_read && p >= FIRST_SAMPLE_PHASE && p <= LAST_SAMPLE_PHASE &&
                    ((p - FIRST_SAMPLE_PHASE) % 3) == 0)
                    rx_shift = {rx_shift[6:0], sda_in};
                bus_levels(p, total, r.scl, r.sda);
                if (p == total - 1) begin
                    r.last      = 1'b1;
                    if (is_read) r.rdata = rx_shift;
                    in_transfer = 0;
                    phase_count = '0;
                end else begin
                    phase_count = 7'(p + 1);
                end
            end
            expected_q.push_back(r);
        endfunction

        function void report(string field, int exp_v, int got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR result %0d, %s: expected %0h, got %0h",
                         checked, field, exp_v, got_v);
        endfunction

        // Compare one result with the oldest prediction
        function void check_result(t_phase_result got);
            t_phase_result exp_r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR result with no transaction pending");
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.scl   !== exp_r.scl)   report("scl", exp_r.scl, got.scl);
            if (got.sda   !== exp_r.sda)   report("sda_release", exp_r.sda, got.sda);
            if (got.busy  !== exp_r.busy)  report("busy", exp_r.busy, got.busy);
            if (got.last  !== exp_r.last)  report("last_phase", exp_r.last, got.last);
            if (got.rdata !== exp_r.rdata) report("read_data", exp_r.rdata, got.rdata);
            if (got.rej   !== exp_r.rej)   report("rejected", exp_r.rej, got.rej);
            checked++;
        endfunction

        function int errors();
            return mismatches + expected_q.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_action = '0;
    logic [2:0] i_device_select = '0;
    logic [7:0] i_register_index = '0;
    logic [7:0] i_write_value = '0;
    logic       i_sda_sample = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_scl;
    logic       o_sda_release;
    logic       o_busy_res;
    logic       o_last_phase;
    logic [7:0] o_read_data;
    logic       o_rejected;

    i2c_phase_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int idle_cycles = 0;

    i2c_register_transaction_sequencer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_device_select  (i_device_select),
        .i_register_index (i_register_index),
        .i_write_value    (i_write_value),
        .i_sda_sample     (i_sda_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_scl            (o_scl),
        .o_sda_release    (o_sda_release),
        .o_busy_res       (o_busy_res),
        .o_last_phase     (o_last_phase),
        .o_read_data      (o_read_data),
        .o_rejected       (o_rejected)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Take results and stall the output at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_scl, o_sda_release, o_busy_res, o_last_phase,
                             o_read_data, o_rejected});
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Stop a hung run: count cycles without any transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offer one input transaction after an optional gap and wait until it is taken
    task automatic send_item(input i2crts_pkg::t_action act, input logic [2:0] sel,
                             input logic [7:0] reg_idx, input logic [7:0] val,
                             input logic sda_in);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_device_select  <= sel;
        i_register_index <= reg_idx;
        i_write_value    <= val;
        i_sda_sample     <= sda_in;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(act, sel, reg_idx, val, sda_in);
        items_sent++;
    endtask

    function automatic logic pick_sda(logic [1:0] mode, int n);
        case (mode)
            SDA_HIGH:   return 1'b1;
            SDA_LOW:    return 1'b0;
            SDA_TOGGLE: return n[0];
            default:    return 1'($urandom_range(1));
        endcase
    endfunction

    // Start a command and tick it through to its stop phase, with some noise commands
    task automatic run_transaction(input i2crts_pkg::t_action act, input logic [2:0] sel,
                                   input logic [7:0] reg_idx, input logic [7:0] val,
                                   input logic [1:0] sda_mode, input int noise_pct);
        int                  n;
        i2crts_pkg::t_action next_act;
        send_item(act, sel, reg_idx, val, pick_sda(sda_mode, 0));
        n = 1;
        while (sb.in_transfer) begin
            if ($urandom_range(99) < noise_pct)
                next_act = i2crts_pkg::t_action'($urandom_range(3, 1));
            else
                next_act = i2crts_pkg::ACT_TICK;
            send_item(next_act, 3'($urandom_range(7)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), pick_sda(sda_mode, n));
            n++;
        end
    endtask

    initial begin
        int                  random_start;
        int                  phase_idx;
        int                  n_idle;
        int                  send_pct_by_phase[4];
        int                  stall_pct_by_phase[4];
        i2crts_pkg::t_action act;

        send_pct_by_phase  = '{0, 62, 0, 35};
        stall_pct_by_phase = '{0, 0, 62, 35};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle bus, unused code, both commands at field extremes
        send_item(i2crts_pkg::ACT_TICK, 3'd0, 8'h00, 8'h00, 1'b0);
        send_item(i2crts_pkg::ACT_NONE, 3'd7, 8'hFF, 8'hFF, 1'b1);
        run_transaction(i2crts_pkg::ACT_WRITE, 3'd7, 8'hFF, 8'h00, SDA_RANDOM, 15);
        run_transaction(i2crts_pkg::ACT_WRITE, 3'd0, 8'h00, 8'hFF, SDA_LOW, 0);
        run_transaction(i2crts_pkg::ACT_READ, 3'd0, 8'h00, 8'h00, SDA_HIGH, 0);
        run_transaction(i2crts_pkg::ACT_READ, 3'd7, 8'hFF, 8'hFF, SDA_TOGGLE, 10);
        run_transaction(i2crts_pkg::ACT_READ, 3'd5, 8'hA5, 8'h5A, SDA_LOW, 0);
        send_item(i2crts_pkg::ACT_TICK, 3'd7, 8'hFF, 8'hFF, 1'b1);

        // Random: mostly complete transfers, some idle noise; idling and output stalls change by quarter
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            phase_idx = (items_sent - random_start) * 4 / RANDOM_ITEMS;
            if (phase_idx > 3) phase_idx = 3;
            send_idle_pct = send_pct_by_phase[phase_idx];
            stall_pct     = stall_pct_by_phase[phase_idx];
            if ($urandom_range(99) < 12) begin
                n_idle = $urandom_range(5, 1);
                repeat (n_idle) begin
                    act = ($urandom_range(1) == 1) ? i2crts_pkg::ACT_NONE
                                                   : i2crts_pkg::ACT_TICK;
                    send_item(act, 3'($urandom_range(7)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 1'($urandom_range(1)));
                end
            end else begin
                act = ($urandom_range(1) == 1) ? i2crts_pkg::ACT_READ
                                               : i2crts_pkg::ACT_WRITE;
                run_transaction(act, 3'($urandom_range(7)), 8'($urandom_range(255)),
                                8'($urandom_range(255)), SDA_RANDOM, 4);
            end
        end

        // Drain the pipeline, then let a few more cycles pass
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d phases: %0d writes, %0d reads, %0d commands rejected while busy",
                 sb.checked, sb.writes_started, sb.reads_started, sb.rejects);
        $display("Mismatches: %0d, predictions left over: %0d",
                 sb.mismatches, sb.expected_q.size());
        if (sb.errors() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
design/i2crts_pkg.sv
design/i2crts_pins.sv
design/i2c_register_transaction_sequencer.sv
tb/i2c_register_transaction_sequencer_tb.sv
